// ===== hw/rtl/encoder_tuning_controller_defines.svh =====
// assertion macros for the encoder tuning controller
`ifndef ENCODER_TUNING_CONTROLLER_DEFINES_SVH
`define ENCODER_TUNING_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

`define ETC_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`define ETC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ETC_ASSERT_ALWAYS(label, expr, msg)

`define ETC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/etc_pkg.sv =====
package etc_pkg;

   localparam int NUM_BANDS = 8;

   localparam int FREQ_W  = 25;
   localparam int STEP_W  = 20;
   localparam int SEL_W   = 3;
   localparam int DEMOD_W = 2;
   localparam int GAIN_W  = 6;
   localparam int BAND_W  = 4;
   localparam int BAND_OUT_W = 3;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_FREQ = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MIN_FREQ = 3'd4;

   localparam logic [FREQ_W-1:0] MAX_FREQ_RESET = 25'd30000000;
   localparam logic [FREQ_W-1:0] MIN_FREQ_RESET = 25'd100;
   localparam logic [FREQ_W-1:0] FREQ_RESET     = 25'd14000000;

   localparam logic [SEL_W-1:0]   STEP_RESET  = 3'd1;
   localparam logic [SEL_W-1:0]   STEP_LAST   = 3'd5;
   localparam logic [DEMOD_W-1:0] DEMOD_LAST  = 2'd2;
   localparam logic signed [GAIN_W-1:0] GAIN_LOW  = -6'sd20;
   localparam logic signed [GAIN_W-1:0] GAIN_HIGH = 6'sd20;

   localparam int BAND_LAST_INT = (NUM_BANDS < 1) ? 0 :
                                  (NUM_BANDS > 16) ? 15 : NUM_BANDS - 1;
   localparam logic [BAND_W-1:0] BAND_LAST  = BAND_W'(BAND_LAST_INT);
   localparam logic [BAND_W-1:0] BAND_RESET = (BAND_LAST_INT < 3) ? BAND_LAST : 4'd3;

   typedef struct packed {
      logic band_button_n;
      logic gain_button_n;
      logic demod_button_n;
      logic step_button_n;
      logic channel_b_level;
      logic edge_falling;
   } req_fields_type;

   typedef struct packed {
      logic                     changed;
      logic [BAND_OUT_W-1:0]    band;
      logic signed [GAIN_W-1:0] audio_gain;
      logic [DEMOD_W-1:0]       demod_mode;
      logic [SEL_W-1:0]         step_index;
      logic [FREQ_W-1:0]        frequency;
   } rsp_fields_type;

   function automatic logic [STEP_W-1:0] step_size(input logic [SEL_W-1:0] idx);
      logic [STEP_W-1:0] size;
      unique case (idx)
         3'd0:    size = 20'd10;
         3'd1:    size = 20'd100;
         3'd2:    size = 20'd1000;
         3'd3:    size = 20'd10000;
         3'd4:    size = 20'd100000;
         default: size = 20'd1000000;
      endcase
      return size;
   endfunction

   function automatic logic [FREQ_W-1:0] band_start(input logic [BAND_W-1:0] idx);
      logic [FREQ_W-1:0] start;
      unique case (idx)
         4'd0:    start = 25'd3500000;
         4'd1:    start = 25'd7000000;
         4'd2:    start = 25'd10100000;
         4'd3:    start = 25'd14000000;
         4'd4:    start = 25'd18060000;
         4'd5:    start = 25'd21000000;
         4'd6:    start = 25'd24800000;
         default: start = 25'd28000000;
      endcase
      return start;
   endfunction

endpackage

// ===== hw/rtl/encoder_tuning_controller.sv =====
// Rotary encoder tuning controller. Each req transaction is one encoder edge; a
// falling edge from channel A steps the setting chosen by the first pressed
// (active low) button: step size, demodulation mode, audio gain or band, else
// the tuned frequency moves by the step size inside the limits held in the csr
// registers (max_frequency at 0x0, min_frequency at 0x4). Every req transaction
// gives exactly one rsp transaction carrying the state after the edge plus a
// changed flag. Unless rsp stalls, one transaction per cycle is taken; the
// registered result appears in the cycle after acceptance. The user must write
// limit registers only while no transaction is in flight (not enforced).
`include "encoder_tuning_controller_defines.svh"

module encoder_tuning_controller (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: edge_falling, channel_b_level, step_button_n, demod_button_n,
   //            gain_button_n, band_button_n, two zero bits
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [etc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser: from_channel_a
   input  logic                                req_tuser,
   // rsp_tdata: frequency, step_index, demod_mode, audio_gain, band, changed
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [etc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [etc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [etc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [etc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   logic [etc_pkg::FREQ_W-1:0]         max_freq_ff, min_freq_ff;
   logic [etc_pkg::FREQ_W-1:0]         freq_ff, freq_in;
   logic [etc_pkg::SEL_W-1:0]          step_ff, step_in;
   logic [etc_pkg::DEMOD_W-1:0]        demod_ff, demod_in;
   logic signed [etc_pkg::GAIN_W-1:0]  gain_ff, gain_in;
   logic [etc_pkg::BAND_W-1:0]         band_ff, band_in;
   logic                               rsp_valid_ff;
   etc_pkg::rsp_fields_type            rsp_data_ff, rsp_data_in;

   etc_pkg::req_fields_type            req;
   logic                               req_accept, csr_write, step_event, up;
   logic [etc_pkg::SEL_W-1:0]          step_idx;
   logic [etc_pkg::STEP_W-1:0]         step_amount;
   logic [etc_pkg::FREQ_W:0]           freq_up_sum, freq_down_floor;

   assign req            = req_tdata[5:0];
   assign req_tready     = !rsp_valid_ff || rsp_tready;
   assign req_accept     = req_tvalid && req_tready;
   assign step_event     = req_tuser && req.edge_falling;
   assign up             = req.channel_b_level;
   assign step_idx       = (step_ff > etc_pkg::STEP_LAST) ? etc_pkg::STEP_LAST : step_ff;
   assign step_amount    = etc_pkg::step_size(step_idx);
   assign freq_up_sum    = {1'b0, freq_ff} + {6'b0, step_amount};
   assign freq_down_floor = {1'b0, min_freq_ff} + {6'b0, step_amount};

   always_comb begin
      freq_in  = freq_ff;
      step_in  = step_ff;
      demod_in = demod_ff;
      gain_in  = gain_ff;
      band_in  = band_ff;
      if (step_event) begin
         priority if (!req.step_button_n) begin
            if (up) begin
               if (step_ff < etc_pkg::STEP_LAST) step_in = step_ff + 3'd1;
            end else if (step_ff != '0) begin
               step_in = step_ff - 3'd1;
            end
         end else if (!req.demod_button_n) begin
            if (up) begin
               if (demod_ff < etc_pkg::DEMOD_LAST) demod_in = demod_ff + 2'd1;
            end else if (demod_ff != '0) begin
               demod_in = demod_ff - 2'd1;
            end
         end else if (!req.gain_button_n) begin
            if (up) begin
               if (gain_ff < etc_pkg::GAIN_HIGH) gain_in = gain_ff + 6'sd1;
            end else if (gain_ff > etc_pkg::GAIN_LOW) begin
               gain_in = gain_ff - 6'sd1;
            end
         end else if (!req.band_button_n) begin
            if (up) begin
               if (band_ff < etc_pkg::BAND_LAST) band_in = band_ff + 4'd1;
            end else if (band_ff != '0) begin
               band_in = band_ff - 4'd1;
            end
            freq_in = etc_pkg::band_start(band_in);
         end else begin
            if (up) begin
               if (freq_up_sum < {1'b0, max_freq_ff})
                  freq_in = freq_up_sum[etc_pkg::FREQ_W-1:0];
            end else if ({1'b0, freq_ff} > freq_down_floor) begin
               freq_in = freq_ff - {5'b0, step_amount};
            end
         end
      end
   end

   always_comb begin
      rsp_data_in.frequency  = freq_in;
      rsp_data_in.step_index = step_in;
      rsp_data_in.demod_mode = demod_in;
      rsp_data_in.audio_gain = gain_in;
      rsp_data_in.band       = band_in[etc_pkg::BAND_OUT_W-1:0];
      rsp_data_in.changed    = step_event;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff      <= etc_pkg::FREQ_RESET;
         step_ff      <= etc_pkg::STEP_RESET;
         demod_ff     <= '0;
         gain_ff      <= '0;
         band_ff      <= etc_pkg::BAND_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            freq_ff  <= freq_in;
            step_ff  <= step_in;
            demod_ff <= demod_in;
            gain_ff  <= gain_in;
            band_ff  <= band_in;
         end
         if (req_tready) rsp_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_freq_ff <= etc_pkg::MAX_FREQ_RESET;
         min_freq_ff <= etc_pkg::MIN_FREQ_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr)
            etc_pkg::ADDR_MAX_FREQ: max_freq_ff <= csr_pwdata[etc_pkg::FREQ_W-1:0];
            etc_pkg::ADDR_MIN_FREQ: min_freq_ff <= csr_pwdata[etc_pkg::FREQ_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         etc_pkg::ADDR_MAX_FREQ: csr_prdata = {7'b0, max_freq_ff};
         etc_pkg::ADDR_MIN_FREQ: csr_prdata = {7'b0, min_freq_ff};
         default:                csr_prdata = '0;
      endcase
   end

   `ETC_ASSERT_ALWAYS(a_step_range, step_ff <= etc_pkg::STEP_LAST, "step index out of range")
   `ETC_ASSERT_ALWAYS(a_gain_range, (gain_ff >= etc_pkg::GAIN_LOW) && (gain_ff <= etc_pkg::GAIN_HIGH), "gain out of range")
   `ETC_ASSERT_ALWAYS(a_band_range, band_ff <= etc_pkg::BAND_LAST, "band out of range")
   `ETC_ASSERT_NEXT(a_idle_edge_keeps_state, req_accept && !step_event, $stable(freq_ff) && $stable(step_ff) && $stable(band_ff) && !rsp_data_ff.changed, "non-step edge changed state")
   `ETC_ASSERT_NEXT(a_accept_gives_result, req_accept, rsp_valid_ff, "accepted transaction has no result")

endmodule
